// ===== sv/rsth_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the control program of the relay schedule thermostat.
// Depends on nothing; the sequencer, the top level and the testbench import it.

package rsth_pkg;

  localparam int DAYS_PER_WEEK     = 7;
  localparam int MINUTES_PER_DAY   = 1440;
  localparam int NEVER_MINUTE      = 2000;
  localparam int LIMIT_REGS        = 4;
  localparam int DEF_NUM_RELAYS    = 4;
  localparam int DEF_SLOTS_PER_DAY = 3;

  localparam int CMD_W        = 2;
  localparam int MINUTE_W     = 11;
  localparam int DAY_W        = 3;
  localparam int TEMP_W       = 12;
  localparam int RIDX_W       = 2;
  localparam int SLOT_W       = 2;
  localparam int TIME_W       = 12;
  localparam int RELAY_BITS_W = 4;
  localparam int CFG_IDX_W    = 3;

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MANUAL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [MINUTE_W-1:0]      minute_of_day;
    logic [DAY_W-1:0]         weekday;
    logic signed [TEMP_W-1:0] temperature;
    logic [RIDX_W-1:0]        relay_index;
    logic                     relay_on;
    logic [SLOT_W-1:0]        slot;
    logic [TIME_W-1:0]        open_minute;
    logic [TIME_W-1:0]        close_minute;
  } item_t;

  typedef struct packed {
    logic [RELAY_BITS_W-1:0] relay_bits;
    logic                    status_changed;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]     index;
    logic signed [TEMP_W-1:0] value;
  } cfg_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_IDLE   = 4'd0,
    OP_TEMP   = 4'd1,
    OP_CHECK  = 4'd2,
    OP_READ   = 4'd3,
    OP_MATCH  = 4'd4,
    OP_LAST   = 4'd5,
    OP_MANUAL = 4'd6,
    OP_WRITE  = 4'd7,
    OP_OUT    = 4'd8
  } op_t;

  // How the step counter moves after a step.
  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_GOTO     = 3'd1,
    SEQ_BRANCH   = 3'd2,
    SEQ_WAIT     = 3'd3,
    SEQ_DISPATCH = 3'd4
  } seq_t;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_SKIP     = 2'd1,
    COND_MORE     = 2'd2,
    COND_OUT_FREE = 2'd3
  } cond_t;

  localparam int PC_W        = 4;
  localparam int UCODE_DEPTH = 2 ** PC_W;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_TEMP   = 4'd1;
  localparam pc_t PC_CHECK  = 4'd2;
  localparam pc_t PC_READ   = 4'd3;
  localparam pc_t PC_MATCH  = 4'd4;
  localparam pc_t PC_LAST   = 4'd5;
  localparam pc_t PC_MANUAL = 4'd6;
  localparam pc_t PC_WRITE  = 4'd7;
  localparam pc_t PC_OUT    = 4'd8;

  typedef struct packed {
    op_t   op;
    seq_t  seq;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Conditions the datapath reports back to the sequencer.
  typedef struct packed {
    logic             accepted;
    logic [CMD_W-1:0] cmd;
    logic             skip_table;
    logic             more;
    logic             out_free;
  } status_t;

  localparam ctrl_t UCODE [UCODE_DEPTH] = '{
    PC_IDLE:   '{op: OP_IDLE,   seq: SEQ_DISPATCH, cond: COND_NONE,     target: PC_IDLE},
    PC_TEMP:   '{op: OP_TEMP,   seq: SEQ_NEXT,     cond: COND_NONE,     target: PC_IDLE},
    PC_CHECK:  '{op: OP_CHECK,  seq: SEQ_BRANCH,   cond: COND_SKIP,     target: PC_OUT},
    PC_READ:   '{op: OP_READ,   seq: SEQ_NEXT,     cond: COND_NONE,     target: PC_IDLE},
    PC_MATCH:  '{op: OP_MATCH,  seq: SEQ_BRANCH,   cond: COND_MORE,     target: PC_READ},
    PC_LAST:   '{op: OP_LAST,   seq: SEQ_GOTO,     cond: COND_NONE,     target: PC_OUT},
    PC_MANUAL: '{op: OP_MANUAL, seq: SEQ_GOTO,     cond: COND_NONE,     target: PC_OUT},
    PC_WRITE:  '{op: OP_WRITE,  seq: SEQ_NEXT,     cond: COND_NONE,     target: PC_IDLE},
    PC_OUT:    '{op: OP_OUT,    seq: SEQ_WAIT,     cond: COND_OUT_FREE, target: PC_IDLE},
    default:   '{op: OP_IDLE,   seq: SEQ_GOTO,     cond: COND_NONE,     target: PC_IDLE}
  };

  function automatic pc_t dispatch_pc(input logic [CMD_W-1:0] cmd);
    pc_t pc;
    unique case (cmd)
      CMD_TICK:   pc = PC_TEMP;
      CMD_MANUAL: pc = PC_MANUAL;
      CMD_WRITE:  pc = PC_WRITE;
      default:    pc = PC_OUT;
    endcase
    return pc;
  endfunction

endpackage

// ===== sv/rsth_chan.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item of any packed type.
// Depends on nothing; the payload types come from rsth_pkg.

interface rsth_chan #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/relay_schedule_thermostat.sv =====
`timescale 1ns / 1ps
// Top level of the relay schedule thermostat: datapath, schedule table and ports.
// Depends on rsth_pkg, the rsth_chan interface and the rsth_seq sequencer.

// The block drives NUM_RELAYS relays from a thermostat and a weekly timetable and
// takes one item at a time on req, answering each with exactly one result item on
// rsp. A tick item applies the temperature limits and, on a new in-range minute and
// weekday, scans every schedule slot of the given weekday; a manual item sets one
// relay; a write item loads one in-range slot. An unknown item goes straight to the
// output step, a manual or write item passes through its own step first, a tick
// that skips the table runs the temperature and check steps, and a tick that scans
// the table adds, since the schedule memory has a single read port, a read step and
// a compare step for every slot and then a step that records the minute. A
// finished result sits in an output register, so the next item is taken as soon as
// the result is loaded even when rsp is stalled. The schedule memory comes out of
// reset reading as "never" in every slot, with no clearing pass. Limit registers are
// for the user to write through cfg only while the block is idle; the block itself
// does not enforce this. Neither req nor cfg accepts anything while rst is high.

module relay_schedule_thermostat #(
  parameter int NUM_RELAYS    = rsth_pkg::DEF_NUM_RELAYS,
  parameter int SLOTS_PER_DAY = rsth_pkg::DEF_SLOTS_PER_DAY
) (
  input logic      clk,
  input logic      rst,
  rsth_chan.sink   req,
  rsth_chan.source rsp,
  rsth_chan.sink   cfg
);
  import rsth_pkg::*;

  localparam int DEPTH       = NUM_RELAYS * DAYS_PER_WEEK * SLOTS_PER_DAY;
  localparam int AW          = $clog2(DEPTH);
  localparam int RW          = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam int SW          = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
  localparam int TEMP_RELAYS = (NUM_RELAYS < LIMIT_REGS) ? NUM_RELAYS : LIMIT_REGS;
  localparam int EXT_W       = (NUM_RELAYS > RELAY_BITS_W) ? NUM_RELAYS : RELAY_BITS_W;

  typedef struct packed {
    logic [TIME_W-1:0] open_minute;
    logic [TIME_W-1:0] close_minute;
  } slot_entry_t;

  // Sequencer and its status feedback.
  ctrl_t   ctrl;
  status_t stat;

  rsth_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Architectural state.
  logic [NUM_RELAYS-1:0]    relay_state;
  logic [NUM_RELAYS-1:0]    relay_state_next;
  logic [MINUTE_W-1:0]      last_minute;
  logic [MINUTE_W-1:0]      last_minute_next;
  logic signed [TEMP_W-1:0] min_lim [LIMIT_REGS];
  logic signed [TEMP_W-1:0] max_lim [LIMIT_REGS];

  // Working registers of the item in flight.
  item_t            item;
  logic             changed;
  logic             changed_next;
  logic [RW-1:0]    rc;
  logic [RW-1:0]    rc_next;
  logic [SW-1:0]    sc;
  logic [SW-1:0]    sc_next;

  // Schedule memory. A slot whose valid bit is clear has never been written and
  // reads as the "never" minute.
  slot_entry_t      tab [DEPTH];
  logic [DEPTH-1:0] tab_vld;
  slot_entry_t      rd_entry;
  logic             rd_vld;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_ok;
  logic             mem_we;
  logic [TIME_W-1:0] open_m;
  logic [TIME_W-1:0] close_m;
  logic [TIME_W-1:0] minute_ext;

  // Output register.
  logic             out_valid;
  result_t          out_data;
  logic             out_load;
  logic [EXT_W-1:0] relay_ext;

  logic accepted;

  assign accepted  = req.valid && req.ready;
  assign req.ready = (ctrl.op == OP_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign stat.accepted   = accepted;
  assign stat.cmd        = req.data.cmd;
  assign stat.out_free   = !out_valid || rsp.ready;
  assign stat.more       = !((rc == RW'(NUM_RELAYS - 1)) && (sc == SW'(SLOTS_PER_DAY - 1)));
  // The table is scanned only for an in-range time on a minute not yet seen.
  assign stat.skip_table = !((int'(item.minute_of_day) < MINUTES_PER_DAY) &&
                             (int'(item.weekday) < DAYS_PER_WEEK) &&
                             (item.minute_of_day != last_minute));

  // Table addresses: relay-major, then weekday, then slot.
  assign rd_addr = AW'((int'(rc) * DAYS_PER_WEEK + int'(item.weekday)) * SLOTS_PER_DAY
                       + int'(sc));
  assign wr_addr = AW'((int'(item.relay_index) * DAYS_PER_WEEK + int'(item.weekday))
                       * SLOTS_PER_DAY + int'(item.slot));
  assign wr_ok   = (int'(item.relay_index) < NUM_RELAYS) &&
                   (int'(item.weekday) < DAYS_PER_WEEK) &&
                   (int'(item.slot) < SLOTS_PER_DAY);

  assign open_m     = rd_vld ? rd_entry.open_minute  : TIME_W'(NEVER_MINUTE);
  assign close_m    = rd_vld ? rd_entry.close_minute : TIME_W'(NEVER_MINUTE);
  assign minute_ext = TIME_W'(item.minute_of_day);
  assign relay_ext  = EXT_W'(relay_state);

  // Datapath next-state logic, one operation per control word.
  always_comb begin
    relay_state_next = relay_state;
    last_minute_next = last_minute;
    changed_next     = changed;
    rc_next          = rc;
    sc_next          = sc;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    unique case (ctrl.op)
      OP_IDLE: begin
        if (accepted) begin
          changed_next = 1'b0;
        end
      end
      OP_TEMP: begin
        // A relay with both limits set goes off below its minimum and on above
        // its maximum; with crossed limits the second test wins and it ends on.
        for (int r = 0; r < TEMP_RELAYS; r++) begin
          if ((min_lim[r] != '0) && (max_lim[r] != '0)) begin
            if (item.temperature < min_lim[r]) begin
              relay_state_next[r] = 1'b0;
              changed_next        = 1'b1;
            end
            if (item.temperature > max_lim[r]) begin
              relay_state_next[r] = 1'b1;
              changed_next        = 1'b1;
            end
          end
        end
      end
      OP_CHECK: begin
        rc_next = '0;
        sc_next = '0;
      end
      OP_READ: begin
      end
      OP_MATCH: begin
        for (int r = 0; r < NUM_RELAYS; r++) begin
          if (RW'(r) == rc) begin
            if (open_m == minute_ext) begin
              relay_state_next[r] = 1'b1;
              changed_next        = 1'b1;
            end else if (close_m == minute_ext) begin
              relay_state_next[r] = 1'b0;
              changed_next        = 1'b1;
            end
          end
        end
        if (sc == SW'(SLOTS_PER_DAY - 1)) begin
          sc_next = '0;
          rc_next = rc + 1'b1;
        end else begin
          sc_next = sc + 1'b1;
        end
      end
      OP_LAST: begin
        last_minute_next = item.minute_of_day;
      end
      OP_MANUAL: begin
        for (int r = 0; r < NUM_RELAYS; r++) begin
          if (int'(item.relay_index) == r) begin
            relay_state_next[r] = item.relay_on;
            changed_next        = 1'b1;
          end
        end
      end
      OP_WRITE: begin
        mem_we = wr_ok;
      end
      OP_OUT: begin
        out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= '0;
      last_minute <= '0;
      changed     <= 1'b0;
      out_valid   <= 1'b0;
      tab_vld     <= '0;
      for (int i = 0; i < LIMIT_REGS; i++) begin
        min_lim[i] <= '0;
        max_lim[i] <= '0;
      end
    end else begin
      relay_state <= relay_state_next;
      last_minute <= last_minute_next;
      changed     <= changed_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        tab_vld[wr_addr] <= 1'b1;
      end
      // Odd register indexes hold the maximum, even ones the minimum.
      if (cfg.valid) begin
        if (cfg.data.index[0]) begin
          max_lim[cfg.data.index[CFG_IDX_W-1:1]] <= cfg.data.value;
        end else begin
          min_lim[cfg.data.index[CFG_IDX_W-1:1]] <= cfg.data.value;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accepted) begin
      item <= req.data;
    end
    rc <= rc_next;
    sc <= sc_next;
    if (out_load) begin
      out_data.relay_bits     <= relay_ext[RELAY_BITS_W-1:0];
      out_data.status_changed <= changed;
    end
  end

  // Schedule memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tab[wr_addr] <= '{open_minute: item.open_minute, close_minute: item.close_minute};
    end
    if (ctrl.op == OP_READ) begin
      rd_entry <= tab[rd_addr];
      rd_vld   <= tab_vld[rd_addr];
    end
  end
endmodule

// ===== sv/rsth_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on rsth_pkg for the control word, status struct and program.

module rsth_seq (
  input  logic            clk,
  input  logic            rst,
  input  rsth_pkg::status_t stat,
  output rsth_pkg::ctrl_t   ctrl
);
  import rsth_pkg::*;

  pc_t  pc;
  pc_t  pc_next;
  logic cond;

  assign ctrl = UCODE[pc];

  always_comb begin
    unique case (ctrl.cond)
      COND_SKIP:     cond = stat.skip_table;
      COND_MORE:     cond = stat.more;
      COND_OUT_FREE: cond = stat.out_free;
      default:       cond = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.seq)
      SEQ_NEXT:     pc_next = pc + 1'b1;
      SEQ_GOTO:     pc_next = ctrl.target;
      SEQ_BRANCH:   pc_next = cond ? ctrl.target : pc + 1'b1;
      SEQ_WAIT:     pc_next = cond ? ctrl.target : pc;
      SEQ_DISPATCH: pc_next = stat.accepted ? dispatch_pc(stat.cmd) : pc;
      default:      pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end
endmodule

// ===== verif/tb_relay_schedule_thermostat.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for relay_schedule_thermostat: directed and random items
// on req are checked against an in-bench prediction of relay states and status.
// Depends on rsth_pkg, the rsth_chan interface and the relay_schedule_thermostat RTL.

module tb_relay_schedule_thermostat;
  import rsth_pkg::*;

  localparam int NUM_RELAYS    = DEF_NUM_RELAYS;
  localparam int SLOTS_PER_DAY = DEF_SLOTS_PER_DAY;
  localparam int TABLE_DEPTH   = NUM_RELAYS * DAYS_PER_WEEK * SLOTS_PER_DAY;
  // A tick that scans the whole table is the slowest item the block handles.
  localparam int TICK_LATENCY  = 2 * NUM_RELAYS * SLOTS_PER_DAY + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TEMP_LOW  = -400;
  localparam int TEMP_HIGH = 1250;
  localparam int MAX_MINUTE_CODE = 2 ** MINUTE_W - 1;
  localparam int MAX_TIME_CODE   = 2 ** TIME_W - 1;
  localparam int POOL_SIZE = 8;
  localparam int RANDOM_ITEMS_PER_PHASE = 330;

  // Limit register indexes: the minimum of relay N sits at 2N, its maximum at 2N+1.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_TEMP0, REG_MAX_TEMP0,
    REG_MIN_TEMP1, REG_MAX_TEMP1,
    REG_MIN_TEMP2, REG_MAX_TEMP2,
    REG_MIN_TEMP3, REG_MAX_TEMP3
  } limit_reg_e;

  localparam limit_reg_e MIN_REG [LIMIT_REGS] =
    '{REG_MIN_TEMP0, REG_MIN_TEMP1, REG_MIN_TEMP2, REG_MIN_TEMP3};
  localparam limit_reg_e MAX_REG [LIMIT_REGS] =
    '{REG_MAX_TEMP0, REG_MAX_TEMP1, REG_MAX_TEMP2, REG_MAX_TEMP3};

  logic clk = 1'b0;
  logic rst;

  rsth_chan #(.T(item_t))   req_if ();
  rsth_chan #(.T(result_t)) rsp_if ();
  rsth_chan #(.T(cfg_t))    cfg_if ();

  relay_schedule_thermostat #(
    .NUM_RELAYS   (NUM_RELAYS),
    .SLOTS_PER_DAY(SLOTS_PER_DAY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the controller state, advanced once per accepted item.
  logic [NUM_RELAYS-1:0]    relays_model;
  logic [MINUTE_W-1:0]      last_minute_model;
  logic [TIME_W-1:0]        open_model [TABLE_DEPTH];
  logic [TIME_W-1:0]        close_model [TABLE_DEPTH];
  logic signed [TEMP_W-1:0] min_model [LIMIT_REGS];
  logic signed [TEMP_W-1:0] max_model [LIMIT_REGS];

  // Relay states and status flags still owed by the block, oldest first.
  result_t expected_results [$];

  int errors = 0;
  int idle_cycles = 0;
  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Minutes shared by table writes and ticks so that the random part actually
  // hits open and close times instead of missing them almost every time.
  logic [MINUTE_W-1:0] minute_pool [POOL_SIZE];

  function automatic int slot_addr(input int r, input int day, input int s);
    return (r * DAYS_PER_WEEK + day) * SLOTS_PER_DAY + s;
  endfunction

  task automatic reset_model();
    int k;
    relays_model = '0;
    last_minute_model = '0;
    for (k = 0; k < TABLE_DEPTH; k++) begin
      open_model[k] = TIME_W'(NEVER_MINUTE);
      close_model[k] = TIME_W'(NEVER_MINUTE);
    end
    for (k = 0; k < LIMIT_REGS; k++) begin
      min_model[k] = '0;
      max_model[k] = '0;
    end
  endtask

  // Applies one item to the model and returns the result the block must produce.
  function automatic result_t predict_relays(input item_t it);
    result_t res;
    logic changed;
    int r;
    int s;
    int k;
    changed = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        // Thermostat first. A relay needs both limits set; when the temperature is
        // under the minimum and over the maximum at once, the "on" wins.
        for (r = 0; r < NUM_RELAYS && r < LIMIT_REGS; r++) begin
          if (min_model[r] != 0 && max_model[r] != 0) begin
            if (it.temperature < min_model[r]) begin
              relays_model[r] = 1'b0;
              changed = 1'b1;
            end
            if (it.temperature > max_model[r]) begin
              relays_model[r] = 1'b1;
              changed = 1'b1;
            end
          end
        end
        // The timetable is only consulted on a fresh, valid minute and weekday.
        if (it.minute_of_day < MINUTES_PER_DAY && it.weekday < DAYS_PER_WEEK &&
            it.minute_of_day != last_minute_model) begin
          for (r = 0; r < NUM_RELAYS; r++) begin
            for (s = 0; s < SLOTS_PER_DAY; s++) begin
              k = slot_addr(r, it.weekday, s);
              if (open_model[k] == it.minute_of_day) begin
                relays_model[r] = 1'b1;
                changed = 1'b1;
              end else if (close_model[k] == it.minute_of_day) begin
                relays_model[r] = 1'b0;
                changed = 1'b1;
              end
            end
          end
          last_minute_model = it.minute_of_day;
        end
      end
      CMD_MANUAL: begin
        if (it.relay_index < NUM_RELAYS) begin
          relays_model[it.relay_index] = it.relay_on;
          changed = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (it.relay_index < NUM_RELAYS && it.weekday < DAYS_PER_WEEK &&
            it.slot < SLOTS_PER_DAY) begin
          k = slot_addr(it.relay_index, it.weekday, it.slot);
          open_model[k] = it.open_minute;
          close_model[k] = it.close_minute;
        end
      end
      default: begin
      end
    endcase
    res.relay_bits = RELAY_BITS_W'(relays_model);
    res.status_changed = changed;
    return res;
  endfunction

  // Temperatures stay inside the sensor range; half of them land on or right
  // next to a programmed limit so the strict comparisons get exercised.
  function automatic logic signed [TEMP_W-1:0] pick_temperature();
    int t;
    int r;
    r = $urandom_range(LIMIT_REGS - 1);
    case ($urandom_range(3))
      0: t = int'(min_model[r]) + int'($urandom_range(4)) - 2;
      1: t = int'(max_model[r]) + int'($urandom_range(4)) - 2;
      default: t = int'($urandom_range(TEMP_HIGH - TEMP_LOW)) + TEMP_LOW;
    endcase
    if (t < TEMP_LOW) t = TEMP_LOW;
    if (t > TEMP_HIGH) t = TEMP_HIGH;
    return TEMP_W'(t);
  endfunction

  function automatic logic [TIME_W-1:0] pick_schedule_minute();
    logic [TIME_W-1:0] m;
    case ($urandom_range(7))
      0: m = TIME_W'(NEVER_MINUTE);
      1: m = TIME_W'($urandom_range(MAX_TIME_CODE, MINUTES_PER_DAY));
      2: m = TIME_W'($urandom_range(MAX_TIME_CODE));
      default: m = TIME_W'(minute_pool[$urandom_range(POOL_SIZE - 1)]);
    endcase
    return m;
  endfunction

  // Every field gets random bits, so fields an item does not use still toggle.
  function automatic item_t scrambled_item();
    logic [63:0] raw;
    item_t it;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    it.temperature = pick_temperature();
    return it;
  endfunction

  // Offers one item on req, with a random gap first, and records what it must
  // produce once the block takes it. Valid stays up afterwards so that a back to
  // back item never sees valid dropped and raised within one step.
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data <= it;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(predict_relays(it));
  endtask

  task automatic send_tick(input int minute, input int day, input int temp);
    item_t it;
    it = scrambled_item();
    it.cmd = CMD_TICK;
    it.minute_of_day = MINUTE_W'(minute);
    it.weekday = DAY_W'(day);
    it.temperature = TEMP_W'(temp);
    send_item(it);
  endtask

  task automatic send_manual(input int relay, input logic on);
    item_t it;
    it = scrambled_item();
    it.cmd = CMD_MANUAL;
    it.relay_index = RIDX_W'(relay);
    it.relay_on = on;
    send_item(it);
  endtask

  task automatic send_write(input int relay, input int day, input int s,
                            input int open_at, input int close_at);
    item_t it;
    it = scrambled_item();
    it.cmd = CMD_WRITE;
    it.relay_index = RIDX_W'(relay);
    it.weekday = DAY_W'(day);
    it.slot = SLOT_W'(s);
    it.open_minute = TIME_W'(open_at);
    it.close_minute = TIME_W'(close_at);
    send_item(it);
  endtask

  // Holds the sender back until every outstanding result has come out. Since each
  // item yields exactly one result, the block is idle once the queue is empty.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_limit(input limit_reg_e idx, input logic signed [TEMP_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, value: v};
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Writes all eight limit registers while the block is idle.
  task automatic load_limits(input int lo [LIMIT_REGS], input int hi [LIMIT_REGS]);
    int r;
    wait_for_results();
    for (r = 0; r < LIMIT_REGS; r++) begin
      write_limit(MIN_REG[r], TEMP_W'(lo[r]));
      min_model[r] = TEMP_W'(lo[r]);
      write_limit(MAX_REG[r], TEMP_W'(hi[r]));
      max_model[r] = TEMP_W'(hi[r]);
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ordered limit pairs, with some relays disabled and some crossed.
  task automatic randomize_limits();
    int lo [LIMIT_REGS];
    int hi [LIMIT_REGS];
    int a;
    int b;
    int r;
    for (r = 0; r < LIMIT_REGS; r++) begin
      a = int'($urandom_range(TEMP_HIGH - TEMP_LOW)) + TEMP_LOW;
      b = int'($urandom_range(TEMP_HIGH - TEMP_LOW)) + TEMP_LOW;
      case ($urandom_range(7))
        0: begin
          lo[r] = 0;
          hi[r] = b;
        end
        1: begin
          lo[r] = a;
          hi[r] = 0;
        end
        2: begin
          lo[r] = (a > b) ? a : b;
          hi[r] = (a > b) ? b : a;
        end
        default: begin
          lo[r] = (a < b) ? a : b;
          hi[r] = (a < b) ? b : a;
        end
      endcase
    end
    load_limits(lo, hi);
  endtask

  // Manual switching, its status flag, and the unknown command.
  task automatic test_manual_and_unknown();
    item_t it;
    // Minute 0 equals the reset value of the last minute, so no table read.
    send_tick(0, 0, TEMP_LOW);
    send_manual(3, 1'b1);
    send_manual(0, 1'b1);
    send_manual(3, 1'b0);
    it = scrambled_item();
    it.cmd = CMD_NONE;
    send_item(it);
    send_manual(0, 1'b0);
  endtask

  // Table writes and ticks that match them, including a later slot overriding an
  // earlier one and an open time taking precedence over a close time in one slot.
  task automatic test_schedule_table();
    send_write(0, 6, 2, MINUTES_PER_DAY - 1, 0);
    send_write(0, 6, 0, 5, MINUTES_PER_DAY - 1);
    send_write(1, 6, 1, MAX_TIME_CODE, MINUTES_PER_DAY - 1);
    send_write(2, 3, 1, 720, 720);
    send_write(3, 0, 0, 0, MAX_TIME_CODE);
    send_manual(1, 1'b1);
    send_tick(MINUTES_PER_DAY - 1, 6, TEMP_HIGH);
    send_tick(720, 3, 0);
  endtask

  // Repeated minutes, out of range minutes and weekdays, and rejected writes.
  task automatic test_minute_guards();
    send_tick(720, 3, 0);
    send_tick(MAX_MINUTE_CODE, 0, 0);
    send_tick(0, DAYS_PER_WEEK, 0);
    send_write(3, DAYS_PER_WEEK, 0, 720, 720);
    send_write(3, 3, 3, 720, 720);
    // The two bad ticks must have left the last minute at 720.
    send_tick(720, 3, 0);
    send_tick(0, 0, 0);
  endtask

  // Thermostat behavior: an ordinary band, a crossed pair, the widest band, and a
  // relay with only one limit set, which must stay out of temperature control.
  task automatic test_temperature_limits();
    int lo [LIMIT_REGS];
    int hi [LIMIT_REGS];
    lo = '{200, 300, TEMP_LOW, 100};
    hi = '{300, 200, TEMP_HIGH, 0};
    load_limits(lo, hi);
    send_tick(0, 0, 100);
    send_tick(0, 0, 250);
    send_tick(0, 0, TEMP_HIGH);
    send_tick(0, 0, TEMP_LOW);
  endtask

  task automatic send_random_item(input int focus_day);
    item_t it;
    int pick;
    it = scrambled_item();
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.cmd = CMD_TICK;
      if ($urandom_range(29) == 0)
        it.minute_of_day = MINUTE_W'($urandom_range(MAX_MINUTE_CODE, MINUTES_PER_DAY));
      else if ($urandom_range(9) == 0)
        it.minute_of_day = MINUTE_W'($urandom_range(MINUTES_PER_DAY - 1));
      else
        it.minute_of_day = minute_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(29) == 0)
        it.weekday = DAY_W'(DAYS_PER_WEEK);
      else if ($urandom_range(3) == 0)
        it.weekday = DAY_W'($urandom_range(DAYS_PER_WEEK - 1));
      else
        it.weekday = DAY_W'(focus_day);
    end else if (pick < 80) begin
      it.cmd = CMD_WRITE;
      it.weekday = ($urandom_range(2) == 0) ? DAY_W'($urandom_range(DAYS_PER_WEEK - 1))
                                            : DAY_W'(focus_day);
      it.slot = SLOT_W'($urandom_range(SLOTS_PER_DAY - 1));
      // A few writes are aimed outside the table and must be dropped.
      case ($urandom_range(19))
        0: it.weekday = DAY_W'(DAYS_PER_WEEK);
        1: it.slot = SLOT_W'(SLOTS_PER_DAY);
        default: begin
        end
      endcase
      it.open_minute = pick_schedule_minute();
      it.close_minute = pick_schedule_minute();
    end else if (pick < 92) begin
      it.cmd = CMD_MANUAL;
    end else if (pick < 95) begin
      it.cmd = CMD_NONE;
    end
    // The remaining items keep every field as scrambled, command included.
    send_item(it);
  endtask

  // Random traffic in three idling phases, each with a fresh set of limits and a
  // fresh pool of minutes. Every so often the sender waits for the block to drain.
  task automatic test_random_traffic();
    int phase;
    int n;
    int i;
    int focus_day;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_stall_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      randomize_limits();
      for (i = 0; i < POOL_SIZE; i++)
        minute_pool[i] = MINUTE_W'($urandom_range(MINUTES_PER_DAY - 1));
      minute_pool[0] = '0;
      minute_pool[1] = MINUTE_W'(MINUTES_PER_DAY - 1);
      focus_day = $urandom_range(DAYS_PER_WEEK - 1);
      for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 39)
          focus_day = $urandom_range(DAYS_PER_WEEK - 1);
        if (n % 64 == 63)
          wait_for_results();
        send_random_item(focus_day);
      end
    end
  endtask

  // Receiver side: ready is redrawn every cycle from the current stall rate.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $error("unexpected result: relay_bits %0h status_changed %0b",
               rsp_if.data.relay_bits, rsp_if.data.status_changed);
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.data.relay_bits !== want.relay_bits) begin
          errors++;
          $error("relay_bits: expected %0h, got %0h",
                 want.relay_bits, rsp_if.data.relay_bits);
        end
        if (rsp_if.data.status_changed !== want.status_changed) begin
          errors++;
          $error("status_changed: expected %0b, got %0b",
                 want.status_changed, rsp_if.data.status_changed);
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_relay_schedule_thermostat failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items run under the first idling pattern.
    send_idle_pct = 20;
    recv_stall_pct = 73;
    test_manual_and_unknown();
    test_schedule_table();
    test_minute_guards();
    test_temperature_limits();
    test_random_traffic();

    // Let everything drain, then give any stray result time to show up.
    wait_for_results();
    repeat (2 * TICK_LATENCY) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_relay_schedule_thermostat passed");
    end else begin
      $display("tb_relay_schedule_thermostat failed");
    end
    $finish;
  end

endmodule
